// File: src/cca_pkg.sv
// ----------------------------------------------------------------------------
// cca_pkg
// Shared types and constants for the contiguous chunk allocator: the
// controller states, the command and status bundles between the controller
// and the datapath, and the fixed field widths of the stream ports.
// ----------------------------------------------------------------------------
`default_nettype none

package cca_pkg;

  // Field widths of the stream payloads.
  localparam int COUNT_W     = 11;
  localparam int CHUNK_W     = 10;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;

  // The chunk map is stored as words of this many bits.
  localparam int WORD_BITS  = 8;
  localparam int WORD_SHIFT = 3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_SCAN_RUN,
    ST_SCAN_NF,
    ST_MARK,
    ST_RESP
  } cca_state_t;

  typedef enum logic [1:0] {
    HINT_KEEP,
    HINT_FROM_SCAN,
    HINT_MIN_START
  } hint_op_t;

  typedef enum logic [1:0] {
    RES_KEEP,
    RES_FAIL,
    RES_ALLOC,
    RES_FREE
  } res_op_t;

  typedef struct packed {
    logic     load_req;
    logic     clear_en;
    logic     scan_init;
    logic     scan_nf;
    logic     scan_en;
    logic     mark_init;
    logic     mark_en;
    logic     out_load;
    hint_op_t hint_op;
    res_op_t  res_op;
  } cca_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic req_ok;
    logic req_free;
    logic scan_done;
    logic scan_found;
    logic mark_done;
    logic pos_at_hint;
  } cca_status_t;

endpackage

`default_nettype wire

// File: src/cca_ctrl.sv
// ----------------------------------------------------------------------------
// cca_ctrl
// Controller of the chunk allocator. Sequences the clearing pass, request
// check, run search, map update, hint search and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module cca_ctrl
  import cca_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire         out_busy,
  input  cca_status_t status,
  output cca_cmd_t    cmd
);

  cca_state_t state;
  cca_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.hint_op = HINT_KEEP;
    cmd.res_op  = RES_KEEP;
    in_ready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (status.clear_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!status.req_ok) begin
          cmd.res_op = RES_FAIL;
          state_next = ST_RESP;
        end else if (status.req_free) begin
          cmd.mark_init = 1'b1;
          state_next    = ST_MARK;
        end else begin
          cmd.scan_init = 1'b1;
          state_next    = ST_SCAN_RUN;
        end
      end
      ST_SCAN_RUN: begin
        cmd.scan_en = 1'b1;
        if (status.scan_done) begin
          if (status.scan_found) begin
            cmd.mark_init = 1'b1;
            state_next    = ST_MARK;
          end else begin
            cmd.res_op = RES_FAIL;
            state_next = ST_RESP;
          end
        end
      end
      ST_SCAN_NF: begin
        cmd.scan_en = 1'b1;
        cmd.scan_nf = 1'b1;
        if (status.scan_done) begin
          cmd.hint_op = HINT_FROM_SCAN;
          state_next  = ST_RESP;
        end
      end
      ST_MARK: begin
        cmd.mark_en = 1'b1;
        if (status.mark_done) begin
          if (status.req_free) begin
            cmd.hint_op = HINT_MIN_START;
            cmd.res_op  = RES_FREE;
            state_next  = ST_RESP;
          end else begin
            cmd.res_op = RES_ALLOC;
            // A run taken at the hint moves the hint to the next free chunk.
            if (status.pos_at_hint) begin
              cmd.scan_init = 1'b1;
              cmd.scan_nf   = 1'b1;
              state_next    = ST_SCAN_NF;
            end else begin
              state_next = ST_RESP;
            end
          end
        end
      end
      ST_RESP: begin
        if (!out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: src/cca_dp.sv
// ----------------------------------------------------------------------------
// cca_dp
// Datapath of the chunk allocator: the chunk map memory, the word-wide run
// scanner, the read-modify-write marker, the hint and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module cca_dp
  import cca_pkg::*;
#(
  parameter int NUM_CHUNKS = 1024
) (
  input  wire                 clk,
  input  wire                 rst,
  input  cca_cmd_t            cmd,
  output cca_status_t         status,
  input  wire                 in_op,
  input  wire [COUNT_W-1:0]   in_count,
  input  wire [CHUNK_W-1:0]   in_start,
  output logic                res_ok,
  output logic [CHUNK_W-1:0]  res_chunk
);

  localparam int IW = $clog2(NUM_CHUNKS + 1);
  localparam int PW = IW + 1;
  localparam int NW = (NUM_CHUNKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW = (NW > 1) ? $clog2(NW) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(NW - 1);
  localparam logic [PW-1:0] N_PW      = PW'(NUM_CHUNKS);
  localparam logic [31:0]   N32       = 32'(NUM_CHUNKS);

  logic [WORD_BITS-1:0] mem [NW];

  // Request and hint.
  logic               req_op;
  logic [COUNT_W-1:0] req_count;
  logic [CHUNK_W-1:0] req_start;
  logic [IW-1:0]      hint;

  // Shared read pipeline.
  logic [AW-1:0]        raddr;
  logic [AW-1:0]        last_addr;
  logic                 issuing;
  logic                 rvalid;
  logic [AW-1:0]        rtag;
  logic [WORD_BITS-1:0] rdata;

  // Scan and mark state.
  logic [PW-1:0] scan_base;
  logic [PW-1:0] scan_len;
  logic [PW-1:0] run;
  logic [PW-1:0] pos;
  logic          scan_done;
  logic          scan_found;
  logic [PW-1:0] mark_lo;
  logic [PW-1:0] mark_hi;
  logic          mark_done;
  logic [AW-1:0] clr_addr;

  // Derived request values.
  logic [PW-1:0] cnt_i;
  logic [PW-1:0] start_i;
  logic [11:0]   free_end;
  logic          req_ok;
  logic [PW-1:0] nf_base;
  logic [PW-1:0] init_base;
  logic [PW-1:0] init_lo;
  logic [PW-1:0] init_hi;

  // Word processing.
  logic [PW-1:0]        word_pos;
  logic [PW-1:0]        idx;
  logic [PW-1:0]        run_v;
  logic [PW-1:0]        pos_v;
  logic                 found_v;
  logic                 bit_used;
  logic [WORD_BITS-1:0] mark_mask;
  logic                 we;
  logic [AW-1:0]        waddr;
  logic [WORD_BITS-1:0] wdata;

  assign cnt_i    = PW'(req_count);
  assign start_i  = PW'(req_start);
  assign free_end = 12'(req_start) + 12'(req_count);

  always_comb begin
    if (req_op) begin
      req_ok = (req_count != '0) && ({20'b0, free_end} <= N32);
    end else begin
      req_ok = (req_count != '0) && ({21'b0, req_count} <= N32);
    end
  end

  assign nf_base   = pos + cnt_i;
  assign init_base = cmd.scan_nf ? nf_base : PW'(hint);
  assign init_lo   = req_op ? start_i : pos;
  assign init_hi   = init_lo + cnt_i;

  assign status.clear_done  = (clr_addr == LAST_ADDR);
  assign status.req_ok      = req_ok;
  assign status.req_free    = req_op;
  assign status.scan_done   = scan_done;
  assign status.scan_found  = scan_found;
  assign status.mark_done   = mark_done;
  assign status.pos_at_hint = (pos == PW'(hint));

  assign word_pos = PW'({rtag, {WORD_SHIFT{1'b0}}});

  // First-fit chain over the bits of one word. Chunks below the scan start
  // and beyond the end of the map count as used.
  always_comb begin
    run_v     = run;
    pos_v     = pos;
    found_v   = 1'b0;
    mark_mask = '0;
    idx       = '0;
    bit_used  = 1'b0;
    for (int j = 0; j < WORD_BITS; j++) begin
      idx      = word_pos + PW'(j);
      bit_used = rdata[j] || (idx < scan_base) || (idx >= N_PW);
      if (!found_v) begin
        if (bit_used) begin
          run_v = '0;
        end else begin
          run_v = run_v + PW'(1);
        end
        if (run_v == scan_len) begin
          found_v = 1'b1;
          pos_v   = idx + PW'(1) - scan_len;
        end
      end
      mark_mask[j] = (idx >= mark_lo) && (idx < mark_hi);
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = rtag;
    wdata = req_op ? (rdata & ~mark_mask) : (rdata | mark_mask);
    if (cmd.clear_en) begin
      we    = 1'b1;
      waddr = clr_addr;
      wdata = '0;
    end else if (cmd.mark_en && rvalid) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_op    <= in_op;
      req_count <= in_count;
      req_start <= in_start;
    end
    case (cmd.res_op)
      RES_FAIL: begin
        res_ok    <= 1'b0;
        res_chunk <= '0;
      end
      RES_ALLOC: begin
        res_ok    <= 1'b1;
        res_chunk <= CHUNK_W'(pos);
      end
      RES_FREE: begin
        res_ok    <= 1'b1;
        res_chunk <= '0;
      end
      default: begin
      end
    endcase
    if (cmd.scan_init) begin
      scan_base <= init_base;
      scan_len  <= cmd.scan_nf ? PW'(1) : cnt_i;
      run       <= '0;
      raddr     <= AW'(init_base >> WORD_SHIFT);
    end else if (cmd.mark_init) begin
      mark_lo   <= init_lo;
      mark_hi   <= init_hi;
      raddr     <= AW'(init_lo >> WORD_SHIFT);
      last_addr <= AW'((init_hi - PW'(1)) >> WORD_SHIFT);
    end else begin
      if ((cmd.scan_en || cmd.mark_en) && issuing && (raddr != last_addr)) begin
        raddr <= AW'(raddr + 1'b1);
      end
      if ((cmd.scan_en || cmd.mark_en) && issuing) begin
        rtag <= raddr;
      end
      if (cmd.scan_en && rvalid && !scan_done) begin
        run <= run_v;
        if (found_v) begin
          pos <= pos_v;
        end
      end
    end
    if (cmd.scan_init) begin
      last_addr <= LAST_ADDR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hint       <= '0;
      issuing    <= 1'b0;
      rvalid     <= 1'b0;
      scan_done  <= 1'b0;
      scan_found <= 1'b0;
      mark_done  <= 1'b0;
      clr_addr   <= '0;
    end else begin
      if (cmd.clear_en && (clr_addr != LAST_ADDR)) begin
        clr_addr <= AW'(clr_addr + 1'b1);
      end
      case (cmd.hint_op)
        HINT_FROM_SCAN: begin
          hint <= scan_found ? IW'(pos) : IW'(NUM_CHUNKS);
        end
        HINT_MIN_START: begin
          if (start_i < PW'(hint)) begin
            hint <= IW'(start_i);
          end
        end
        default: begin
        end
      endcase
      if (cmd.scan_init) begin
        rvalid     <= 1'b0;
        issuing    <= (init_base < N_PW);
        scan_done  <= (init_base >= N_PW);
        scan_found <= 1'b0;
      end else if (cmd.mark_init) begin
        rvalid    <= 1'b0;
        issuing   <= 1'b1;
        mark_done <= 1'b0;
      end else begin
        if ((cmd.scan_en || cmd.mark_en) && issuing) begin
          rvalid <= 1'b1;
          if (raddr == last_addr) begin
            issuing <= 1'b0;
          end
        end else begin
          rvalid <= 1'b0;
        end
        if (cmd.scan_en && rvalid && !scan_done) begin
          if (found_v) begin
            scan_done  <= 1'b1;
            scan_found <= 1'b1;
          end else if (rtag == LAST_ADDR) begin
            scan_done <= 1'b1;
          end
        end
        if (cmd.mark_en && rvalid && (rtag == last_addr)) begin
          mark_done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: src/contiguous_chunk_allocator.sv
// ----------------------------------------------------------------------------
// contiguous_chunk_allocator
// First-fit allocator over a map of fixed-size chunks with a hint to the
// lowest free chunk. Allocate requests take a run of free chunks, free
// requests release one.
//
//   Channel  Dir  tdata (low bit up)                      tuser
//   s_*      in   run_len[10:0], start_chunk[20:11]       op (0 alloc, 1 free)
//   m_*      out  ok[0], result_chunk[10:1]               -
//
// The map is held as 8-chunk words in one memory. After reset a clearing
// pass writes one word a cycle over the whole map before the first beat
// is taken. An allocate is checked, scans the map from the hint for a run
// and marks the words of the run; a run taken at the hint is followed by a
// scan for the next free chunk, which becomes the new hint. A free is
// checked, clears the words of its run and lowers the hint to its start if
// that is below it. A request refused at the check, and an allocate that
// finds no run, go straight to the result. The next beat is taken at the
// earliest in the cycle after the result is loaded. One request is handled
// at a time; a result beat waits in the output register while the next
// request is taken, and the following result waits until that beat is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module contiguous_chunk_allocator
  import cca_pkg::*;
#(
  parameter int NUM_CHUNKS = 1024
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    s_tvalid,
  output logic                   s_tready,
  input  wire [IN_TDATA_W-1:0]   s_tdata,   // run_len, start_chunk
  input  wire [0:0]              s_tuser,   // op
  output logic                   m_tvalid,
  input  wire                    m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata    // ok, result_chunk
);

  cca_cmd_t           cmd;
  cca_status_t        status;
  logic               res_ok;
  logic [CHUNK_W-1:0] res_chunk;
  logic               out_busy;

  assign out_busy = m_tvalid && !m_tready;

  cca_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .out_busy (out_busy),
    .status   (status),
    .cmd      (cmd)
  );

  cca_dp #(
    .NUM_CHUNKS (NUM_CHUNKS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_op     (s_tuser[0]),
    .in_count  (s_tdata[COUNT_W-1:0]),
    .in_start  (s_tdata[COUNT_W+CHUNK_W-1:COUNT_W]),
    .res_ok    (res_ok),
    .res_chunk (res_chunk)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {{(OUT_TDATA_W - CHUNK_W - 1){1'b0}}, res_chunk, res_ok};
    end
  end

endmodule

`default_nettype wire
